/* rtl/io_ports_timer_keyboard_macros.svh */
// Assertion macros for the I/O port, timer and keyboard block.
// Used by the checker module only; no other dependencies.
`ifndef IO_PORTS_TIMER_KEYBOARD_MACROS_SVH
`define IO_PORTS_TIMER_KEYBOARD_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPTK_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("iptk assertion failed");

// Next-cycle implication; cons may start with a fixed delay.
`define IPTK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> cons) \
    else $error("iptk assertion failed");

`endif

/* rtl/iptk_pkg.sv */
// Shared types, constants and helpers for the I/O port, timer and keyboard block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iptk_pkg;

  localparam int unsigned KEY_ROWS_DEFAULT = 10;
  localparam int unsigned PORT_COUNT       = 32;
  localparam int unsigned TICK_W           = 14;
  localparam int unsigned IRQ_W            = 7;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_KEY   = 2'd3
  } iptk_op_e;

  // Port numbers with special behavior
  localparam logic [4:0] PORT_STATUS    = 5'h00;
  localparam logic [4:0] PORT_LCD_INIT  = 5'h0D;
  localparam logic [4:0] PORT_TIMER_CTL = 5'h15;
  localparam logic [4:0] PORT_TIMER_VAL = 5'h17;
  localparam logic [4:0] PORT_ROWSEL_HI = 5'h18;
  localparam logic [4:0] PORT_ROWSEL_LO = 5'h19;
  localparam logic [4:0] PORT_FLAGS     = 5'h1A;
  localparam logic [4:0] PORT_KEYS      = 5'h1B;

  // Ports that read back a fixed ID byte
  localparam logic [4:0] PORT_FIXED_A_LO = 5'h06;
  localparam logic [4:0] PORT_FIXED_A_HI = 5'h0B;
  localparam logic [4:0] PORT_FIXED_B_LO = 5'h10;
  localparam logic [4:0] PORT_FIXED_B_HI = 5'h13;
  localparam logic [4:0] PORT_FIXED_C    = 5'h1E;
  localparam logic [4:0] PORT_FIXED_D    = 5'h1F;

  localparam logic [7:0] FIXED_READ    = 8'h14;
  localparam logic [7:0] LCD_INIT_RST  = 8'h40;
  localparam logic [7:0] STATUS_MASK   = 8'h20;
  localparam logic [7:0] STATUS_SET    = 8'h04;
  localparam logic [7:0] FLAGS_SET     = 8'h02;
  localparam logic [7:0] KEY_BIT_MSB   = 8'h80;
  localparam logic [5:0] TICK_L1_MASK  = 6'd63;

  // Timer control register bits
  localparam int unsigned CTL_OSC_EN   = 1;
  localparam int unsigned CTL_L3_EN    = 2;
  localparam int unsigned CTL_TIMER_EN = 3;
  localparam int unsigned CTL_PRE_LO   = 4;
  localparam int unsigned CTL_PRE_HI   = 5;
  localparam int unsigned CTL_MASK_ALL = 7;

  // Interrupt raise bits (level n is bit n-1)
  localparam int unsigned IRQ_BIT_L1 = 0;
  localparam int unsigned IRQ_BIT_L2 = 1;
  localparam int unsigned IRQ_BIT_L3 = 2;
  localparam int unsigned IRQ_BIT_L5 = 4;

  // Fixed and derived views of the port file for the other units
  typedef struct packed {
    logic [7:0]  ctl;
    logic [7:0]  reload;
    logic [15:0] row_sel;
  } iptk_port_view_t;

  function automatic logic [TICK_W-1:0] prescale_mask(input logic [1:0] sel);
    logic [TICK_W-1:0] m;
    case (sel)
      2'd0:    m = TICK_W'(0);
      2'd1:    m = TICK_W'(15);
      2'd2:    m = TICK_W'(127);
      default: m = TICK_W'(8191);
    endcase
    return m;
  endfunction

  function automatic logic is_fixed_port(input logic [4:0] p);
    return ((p >= PORT_FIXED_A_LO) && (p <= PORT_FIXED_A_HI)) ||
           ((p >= PORT_FIXED_B_LO) && (p <= PORT_FIXED_B_HI)) ||
           (p == PORT_FIXED_C) || (p == PORT_FIXED_D);
  endfunction

endpackage

`default_nettype wire

/* rtl/iptk_if.sv */
// Valid/ready channel interfaces for the request and result words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface iptk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [4:0] port;
  logic [7:0] write_data;
  logic [3:0] key_row;
  logic [2:0] key_col;
  logic       key_down;

  modport source (output valid, opcode, port, write_data, key_row, key_col, key_down,
                  input ready);
  modport sink   (input valid, opcode, port, write_data, key_row, key_col, key_down,
                  output ready);
endinterface

interface iptk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [6:0] irq_raise;

  modport source (output valid, read_data, irq_raise, input ready);
  modport sink   (input valid, read_data, irq_raise, output ready);
endinterface

`default_nettype wire

/* rtl/iptk_ports.sv */
// Port register file with the read mux.
// Depends on iptk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iptk_ports
  import iptk_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire logic [4:0]      port_i,
  input  wire logic [7:0]      wdata_i,
  input  wire logic [7:0]      timer_i,
  input  wire logic [7:0]      keys_i,
  output      logic [7:0]      rdata_o,
  output      iptk_port_view_t view_o
);

  logic [7:0] regs_q [PORT_COUNT];
  logic [7:0] cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        regs_q[i] <= (5'(i) == PORT_LCD_INIT) ? LCD_INIT_RST : 8'h00;
      end
    end else if (wr_en_i) begin
      regs_q[port_i] <= wdata_i;
    end
  end

  assign cur = regs_q[port_i];

  always_comb begin
    case (port_i)
      PORT_STATUS:    rdata_o = (cur & STATUS_MASK) | STATUS_SET;
      PORT_TIMER_VAL: rdata_o = timer_i;
      PORT_FLAGS:     rdata_o = cur | FLAGS_SET;
      PORT_KEYS:      rdata_o = keys_i;
      default:        rdata_o = is_fixed_port(port_i) ? FIXED_READ : cur;
    endcase
  end

  assign view_o.ctl     = regs_q[PORT_TIMER_CTL];
  assign view_o.reload  = regs_q[PORT_TIMER_VAL];
  assign view_o.row_sel = {regs_q[PORT_ROWSEL_HI], regs_q[PORT_ROWSEL_LO]};

endmodule

`default_nettype wire

/* rtl/iptk_timer.sv */
// Tick counter, 8-bit timer and the tick-driven interrupt levels.
// Depends on iptk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iptk_timer
  import iptk_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             tick_i,
  input  wire logic             load_i,
  input  wire logic [7:0]       load_data_i,
  input  wire iptk_port_view_t  view_i,
  output      logic [7:0]       timer_o,
  output      logic [IRQ_W-1:0] irq_o
);

  logic [TICK_W-1:0] tick_q, tick_d;
  logic [7:0]        timer_q, timer_d;
  logic [TICK_W-1:0] pmask;
  logic              masked, osc_en, step;
  logic [7:0]        timer_next;

  assign tick_d = tick_q + TICK_W'(1);
  assign masked = view_i.ctl[CTL_MASK_ALL];
  assign osc_en = view_i.ctl[CTL_OSC_EN];
  assign pmask  = prescale_mask(view_i.ctl[CTL_PRE_HI:CTL_PRE_LO]);
  assign step   = osc_en && view_i.ctl[CTL_TIMER_EN] && ((tick_d & pmask) == '0);
  // zero reloads, otherwise count up with wrap
  assign timer_next = (timer_q == 8'h00) ? view_i.reload : timer_q + 8'd1;

  always_comb begin
    timer_d = timer_q;
    irq_o   = '0;
    if (load_i) begin
      timer_d = load_data_i;
    end else if (tick_i) begin
      if (step) begin
        timer_d = timer_next;
      end
      irq_o[IRQ_BIT_L1] = osc_en && !masked && (tick_d[5:0] & TICK_L1_MASK) == 6'd0;
      irq_o[IRQ_BIT_L3] = osc_en && !masked && view_i.ctl[CTL_L3_EN] && (tick_d == '0);
      irq_o[IRQ_BIT_L5] = step && !masked && (timer_next == 8'h00);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      timer_q <= '0;
    end else begin
      if (tick_i) begin
        tick_q <= tick_d;
      end
      timer_q <= timer_d;
    end
  end

  assign timer_o = timer_q;

endmodule

`default_nettype wire

/* rtl/iptk_keys.sv */
// Key matrix: press/release update, new-press interrupt and row scan.
// Depends on iptk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iptk_keys
  import iptk_pkg::*;
#(
  parameter int unsigned KEY_ROWS = KEY_ROWS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        key_en_i,
  input  wire logic [3:0]  row_i,
  input  wire logic [2:0]  col_i,
  input  wire logic        down_i,
  input  wire logic [15:0] row_sel_i,
  output      logic        press_o,
  output      logic [7:0]  scan_o
);

  logic [7:0] matrix_q [KEY_ROWS];
  logic [7:0] bit_mask, row_val, pressed;
  logic       hit;

  assign bit_mask = KEY_BIT_MSB >> col_i;

  always_comb begin
    row_val = '0;
    hit     = 1'b0;
    pressed = '0;
    for (int r = 0; r < KEY_ROWS; r++) begin
      if (row_i == 4'(r)) begin
        row_val = matrix_q[r];
        hit     = 1'b1;
      end
      if (!row_sel_i[r]) begin
        pressed = pressed | matrix_q[r];
      end
    end
  end

  // rows beyond the matrix are dropped
  assign press_o = key_en_i && hit && down_i && ((row_val & bit_mask) == 8'h00);
  assign scan_o  = ~pressed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < KEY_ROWS; r++) begin
        matrix_q[r] <= '0;
      end
    end else if (key_en_i) begin
      for (int r = 0; r < KEY_ROWS; r++) begin
        if (row_i == 4'(r)) begin
          matrix_q[r] <= down_i ? (matrix_q[r] | bit_mask) : (matrix_q[r] & ~bit_mask);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/io_ports_timer_keyboard.sv */
// Top level of the I/O port, timer and keyboard block.
// Depends on iptk_pkg, iptk_if, iptk_ports, iptk_timer, iptk_keys.
//
//   channel | dir | word fields
//   --------+-----+-----------------------------------------------------------
//   in_i    | in  | opcode, port, write_data, key_row, key_col, key_down
//   out_o   | out | read_data, irq_raise
//
// One word per cycle sustained while out_o is not stalled. A word is held in the input register,
// is executed against the port file, timer and key matrix as it leaves it, and lands in the
// result register, from where out_o shows it as valid.
// Reset (rst_ni, async, low) clears both stages, the counters, the key matrix
// and the port file (port 0x0D comes up as 0x40).
// A stall on out_o holds the result; one more word is taken into the input
// register and waits there, then in_i.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module io_ports_timer_keyboard
  import iptk_pkg::*;
#(
  parameter int unsigned KEY_ROWS = KEY_ROWS_DEFAULT
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  iptk_in_if.sink    in_i,
  iptk_out_if.source out_o
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  iptk_op_e   s1_op_q;
  logic [4:0] s1_port_q;
  logic [7:0] s1_wdata_q;
  logic [3:0] s1_row_q;
  logic [2:0] s1_col_q;
  logic       s1_down_q;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_rdata_q, out_rdata_d;
  logic [IRQ_W-1:0] out_irq_q, out_irq_d;

  logic out_free, advance, accept;
  logic tick_en, wr_en, key_en, timer_load;

  iptk_port_view_t  view;
  logic [7:0]       port_rdata, timer_val, key_scan;
  logic [IRQ_W-1:0] timer_irq;
  logic             key_press;

  // result register frees up this cycle, so the input stage may move on
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign accept   = in_i.valid && in_i.ready;

  // state updates happen only as a word leaves the input register
  assign tick_en    = advance && (s1_op_q == OP_TICK);
  assign wr_en      = advance && (s1_op_q == OP_WRITE);
  assign key_en     = advance && (s1_op_q == OP_KEY);
  assign timer_load = wr_en && (s1_port_q == PORT_TIMER_VAL);

  iptk_ports u_ports (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (wr_en),
    .port_i  (s1_port_q),
    .wdata_i (s1_wdata_q),
    .timer_i (timer_val),
    .keys_i  (key_scan),
    .rdata_o (port_rdata),
    .view_o  (view)
  );

  iptk_timer u_timer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_en),
    .load_i      (timer_load),
    .load_data_i (s1_wdata_q),
    .view_i      (view),
    .timer_o     (timer_val),
    .irq_o       (timer_irq)
  );

  iptk_keys #(
    .KEY_ROWS (KEY_ROWS)
  ) u_keys (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_en_i  (key_en),
    .row_i     (s1_row_q),
    .col_i     (s1_col_q),
    .down_i    (s1_down_q),
    .row_sel_i (view.row_sel),
    .press_o   (key_press),
    .scan_o    (key_scan)
  );

  always_comb begin
    s1_valid_d = accept ? 1'b1 : (out_free ? 1'b0 : s1_valid_q);
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
    out_rdata_d = out_rdata_q;
    out_irq_d   = out_irq_q;
    if (advance) begin
      out_rdata_d = '0;
      out_irq_d   = '0;
      case (s1_op_q)
        OP_TICK:  out_irq_d = timer_irq;
        OP_READ:  out_rdata_d = port_rdata;
        OP_WRITE: out_irq_d = '0;
        OP_KEY:   out_irq_d[IRQ_BIT_L2] = key_press;
        default:  out_irq_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= iptk_op_e'(in_i.opcode);
      s1_port_q  <= in_i.port;
      s1_wdata_q <= in_i.write_data;
      s1_row_q   <= in_i.key_row;
      s1_col_q   <= in_i.key_col;
      s1_down_q  <= in_i.key_down;
    end
    out_rdata_q <= out_rdata_d;
    out_irq_q   <= out_irq_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_rdata_q;
  assign out_o.irq_raise = out_irq_q;

endmodule

`default_nettype wire

/* rtl/iptk_checker.sv */
// Port-level checks for the I/O port, timer and keyboard block, bound to the top.
// Depends on io_ports_timer_keyboard_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "io_ports_timer_keyboard_macros.svh"

module iptk_port_checks (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] read_data_i,
  input wire logic [6:0] irq_raise_i
);

  // a pending result holds until taken
  `IPTK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  // an accepted word shows a result once it has passed the input and result registers
  `IPTK_ASSERT_NEXT(a_latency, clk_i, rst_ni, in_valid_i && in_ready_i, ##1 out_valid_i)
  // with the result register empty, the input side is open
  `IPTK_ASSERT_NOW(a_no_bubble, clk_i, rst_ni, !out_valid_i, in_ready_i)
  // only levels 1, 2, 3 and 5 are ever raised
  `IPTK_ASSERT_NOW(a_irq_levels, clk_i, rst_ni, out_valid_i, (irq_raise_i & 7'h68) == 7'h00)
  // a read raises nothing, other words return no data
  `IPTK_ASSERT_NOW(a_rd_irq_excl, clk_i, rst_ni, out_valid_i, !(|read_data_i && |irq_raise_i))

endmodule

bind io_ports_timer_keyboard iptk_port_checks u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .read_data_i (out_o.read_data),
  .irq_raise_i (out_o.irq_raise)
);

`default_nettype wire

/* tb/iptk_checker.sv */
// Scoreboard for io_ports_timer_keyboard: watches both channels, predicts each result word.
// Depends on iptk_pkg and the channel interfaces in iptk_if.
`timescale 1ns / 1ps

module iptk_checker
  import iptk_pkg::*;
#(
  parameter int unsigned KEY_ROWS = KEY_ROWS_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  iptk_in_if   in_mon,
  iptk_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [7:0]       read_data;
    logic [IRQ_W-1:0] irq_raise;
  } iptk_result_t;

  // shadow copy of the block state
  logic [7:0]        port_file [PORT_COUNT];
  logic [TICK_W-1:0] tick_cnt;
  logic [7:0]        timer_val;
  logic [7:0]        key_rows  [KEY_ROWS];

  iptk_result_t due_results [$];
  int           fail_cnt = 0;

  assign fail_count_o = fail_cnt;

  // prints are capped so a broken block cannot flood the log
  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_cnt < 40) begin
      $display("%0t: result word %s mismatch, got 0x%0h expected 0x%0h",
               $time, what, got, want);
    end
    fail_cnt++;
  endtask

  task automatic reset_model();
    for (int i = 0; i < PORT_COUNT; i++) port_file[i] = 8'h00;
    port_file[PORT_LCD_INIT] = LCD_INIT_RST;
    for (int r = 0; r < KEY_ROWS; r++) key_rows[r] = 8'h00;
    tick_cnt  = '0;
    timer_val = 8'h00;
    due_results.delete();
  endtask

  task automatic exec_word(input iptk_op_e op, input logic [4:0] p, input logic [7:0] data,
                           input logic [3:0] row, input logic [2:0] col, input logic down,
                           output iptk_result_t res);
    logic [7:0]        ctl;
    logic [7:0]        key_bit;
    logic [7:0]        held;
    logic [15:0]       row_sel;
    logic [TICK_W-1:0] pre;
    logic              masked;
    res = '0;
    case (op)
      OP_TICK: begin
        tick_cnt = tick_cnt + 1'b1;
        ctl      = port_file[PORT_TIMER_CTL];
        masked   = ctl[CTL_MASK_ALL];
        case (ctl[CTL_PRE_HI:CTL_PRE_LO])
          2'd0:    pre = TICK_W'(0);
          2'd1:    pre = TICK_W'(15);
          2'd2:    pre = TICK_W'(127);
          default: pre = TICK_W'(8191);
        endcase
        if (ctl[CTL_OSC_EN]) begin
          if ((tick_cnt[5:0] == 6'd0) && !masked) res.irq_raise[IRQ_BIT_L1] = 1'b1;
          if ((tick_cnt == '0) && ctl[CTL_L3_EN] && !masked) res.irq_raise[IRQ_BIT_L3] = 1'b1;
          if (((tick_cnt & pre) == '0) && ctl[CTL_TIMER_EN]) begin
            timer_val = (timer_val == 8'h00) ? port_file[PORT_TIMER_VAL] : timer_val + 8'd1;
            if ((timer_val == 8'h00) && !masked) res.irq_raise[IRQ_BIT_L5] = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (((p >= PORT_FIXED_A_LO) && (p <= PORT_FIXED_A_HI)) ||
            ((p >= PORT_FIXED_B_LO) && (p <= PORT_FIXED_B_HI)) ||
            (p == PORT_FIXED_C) || (p == PORT_FIXED_D)) begin
          res.read_data = FIXED_READ;
        end else if (p == PORT_STATUS) begin
          res.read_data = (port_file[p] & STATUS_MASK) | STATUS_SET;
        end else if (p == PORT_TIMER_VAL) begin
          res.read_data = timer_val;
        end else if (p == PORT_FLAGS) begin
          res.read_data = port_file[p] | FLAGS_SET;
        end else if (p == PORT_KEYS) begin
          // a clear select bit puts that row on the sense lines
          row_sel = {port_file[PORT_ROWSEL_HI], port_file[PORT_ROWSEL_LO]};
          held    = 8'h00;
          for (int r = 0; r < KEY_ROWS; r++) begin
            if (!row_sel[r]) held = held | key_rows[r];
          end
          res.read_data = ~held;
        end else begin
          res.read_data = port_file[p];
        end
      end
      OP_WRITE: begin
        port_file[p] = data;
        if (p == PORT_TIMER_VAL) timer_val = data;
      end
      default: begin
        if (row < KEY_ROWS) begin
          key_bit = KEY_BIT_MSB >> col;
          if (down) begin
            if ((key_rows[row] & key_bit) == 8'h00) res.irq_raise[IRQ_BIT_L2] = 1'b1;
            key_rows[row] = key_rows[row] | key_bit;
          end else begin
            key_rows[row] = key_rows[row] & ~key_bit;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    iptk_result_t got;
    iptk_result_t want;
    iptk_result_t pred;
    if (!rst_ni) begin
      reset_model();
    end else begin
      // output first: a word accepted now cannot leave in the same cycle
      if (out_mon.valid && out_mon.ready) begin
        got.read_data = out_mon.read_data;
        got.irq_raise = out_mon.irq_raise;
        if (due_results.size() == 0) begin
          report_mismatch("with none due", got, 0);
        end else begin
          want = due_results.pop_front();
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.irq_raise !== want.irq_raise)
            report_mismatch("irq_raise", got.irq_raise, want.irq_raise);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        exec_word(iptk_op_e'(in_mon.opcode), in_mon.port, in_mon.write_data,
                  in_mon.key_row, in_mon.key_col, in_mon.key_down, pred);
        due_results.push_back(pred);
      end
    end
    pending_o <= due_results.size();
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for io_ports_timer_keyboard: clock, reset, stimulus and verdict.
// Depends on iptk_pkg, iptk_if, the block itself and tb/iptk_checker.sv.
`timescale 1ns / 1ps

module tb_top;
  import iptk_pkg::*;

  localparam int unsigned KEY_ROWS     = KEY_ROWS_DEFAULT;
  localparam int unsigned RANDOM_WORDS = 1800;
  localparam int unsigned IDLE_PCT     = 27;
  // long quiet window: neither side idles while these words go out
  localparam int unsigned CALM_FIRST   = 700;
  localparam int unsigned CALM_LAST    = 1000;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned STALL_LIMIT  = 2000;
  // extra wait after the queue empties, to let the last results drain
  localparam int unsigned DRAIN_CYCLES = 8;

  // oscillator and timer on, prescale off: timer steps on every tick
  localparam logic [7:0] CTL_FAST = (8'd1 << CTL_OSC_EN) | (8'd1 << CTL_TIMER_EN);

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        no_idle = 1'b0;
  int unsigned stall_cycles = 0;
  int          fail_count;
  int          pending;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  iptk_in_if  in_if ();
  iptk_out_if out_if ();

  io_ports_timer_keyboard #(
    .KEY_ROWS(KEY_ROWS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  iptk_checker #(
    .KEY_ROWS(KEY_ROWS)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Result side: back-pressure at random, except inside the quiet window.
  always @(negedge clk_i) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Drive one request word. Entered and left at a falling edge; valid stays
  // high between back-to-back words, dropped only for a random gap.
  task automatic send_word(input iptk_op_e op, input logic [4:0] p, input logic [7:0] data,
                           input logic [3:0] row, input logic [2:0] col, input logic down);
    while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.port       <= p;
    in_if.write_data <= data;
    in_if.key_row    <= row;
    in_if.key_col    <= col;
    in_if.key_down   <= down;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Fields an operation does not use carry noise, so they are seen to be ignored.
  task automatic tick();
    send_word(OP_TICK, 5'($urandom_range(31)), 8'($urandom_range(255)),
              4'($urandom_range(15)), 3'($urandom_range(7)), 1'($urandom_range(1)));
  endtask

  task automatic read_port(input logic [4:0] p);
    send_word(OP_READ, p, 8'($urandom_range(255)),
              4'($urandom_range(15)), 3'($urandom_range(7)), 1'($urandom_range(1)));
  endtask

  task automatic write_port(input logic [4:0] p, input logic [7:0] data);
    send_word(OP_WRITE, p, data,
              4'($urandom_range(15)), 3'($urandom_range(7)), 1'($urandom_range(1)));
  endtask

  task automatic key(input logic [3:0] row, input logic [2:0] col, input logic down);
    send_word(OP_KEY, 5'($urandom_range(31)), 8'($urandom_range(255)), row, col, down);
  endtask

  // Random control byte: mostly oscillator on and interrupts unmasked.
  function automatic logic [7:0] rand_ctl();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if ($urandom_range(99) < 85) c[CTL_OSC_EN] = 1'b1;
    if ($urandom_range(99) < 75) c[CTL_MASK_ALL] = 1'b0;
    return c;
  endfunction

  task automatic random_word();
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    if (roll < 45) begin
      tick();
    end else if (roll < 65) begin
      // keys and timer reads are the interesting ones, bias toward them
      if (pick < 15)      read_port(PORT_KEYS);
      else if (pick < 25) read_port(PORT_TIMER_VAL);
      else                read_port(5'($urandom_range(31)));
    end else if (roll < 80) begin
      if (pick < 35) begin
        write_port(PORT_TIMER_CTL, rand_ctl());
      end else if (pick < 55) begin
        // values just below the wrap make level 5 come quickly; zero sticks
        if ($urandom_range(3) == 0) write_port(PORT_TIMER_VAL, 8'($urandom_range(255)));
        else                        write_port(PORT_TIMER_VAL, 8'($urandom_range(8'hFF, 8'hF0)));
      end else if (pick < 75) begin
        // sparse ones select more rows
        write_port($urandom_range(1) ? PORT_ROWSEL_HI : PORT_ROWSEL_LO,
                   8'($urandom_range(255) & $urandom_range(255)));
      end else begin
        write_port(5'($urandom_range(31)), 8'($urandom_range(255)));
      end
    end else begin
      key((pick < 85) ? 4'($urandom_range(KEY_ROWS - 1)) : 4'($urandom_range(15)),
          3'($urandom_range(7)), $urandom_range(99) < 60);
    end
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_TICK;
    in_if.port       = '0;
    in_if.write_data = '0;
    in_if.key_row    = '0;
    in_if.key_col    = '0;
    in_if.key_down   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed part ---
    tick();                              // oscillator off: nothing raised
    read_port(PORT_STATUS);              // status reads 0x04 after reset
    read_port(PORT_LCD_INIT);            // comes up as 0x40
    read_port(PORT_FIXED_A_LO);          // fixed ID byte, low end
    read_port(PORT_FIXED_D);             // fixed ID byte, top port
    write_port(PORT_STATUS, 8'hFF);
    read_port(PORT_STATUS);              // only the 0x20 bit shows through
    read_port(PORT_FLAGS);               // bit 1 always reads set
    key(4'd0, 3'd0, 1'b1);               // new press raises level 2
    key(4'd0, 3'd0, 1'b1);               // key already down: nothing
    key(4'(KEY_ROWS - 1), 3'd7, 1'b1);   // last row, last column
    key(4'd15, 3'd3, 1'b1);              // row past the matrix is ignored
    read_port(PORT_KEYS);                // all rows selected
    write_port(PORT_ROWSEL_LO, 8'hFF);
    write_port(PORT_ROWSEL_HI, 8'hFF);
    read_port(PORT_KEYS);                // no rows selected: all ones
    key(4'd0, 3'd0, 1'b0);               // release
    write_port(PORT_TIMER_VAL, 8'hFE);   // loads the timer too
    write_port(PORT_TIMER_CTL, CTL_FAST);
    tick();                              // timer 0xFF
    tick();                              // wraps to zero: level 5
    tick();                              // reloads from the timer port
    read_port(PORT_TIMER_VAL);
    write_port(PORT_TIMER_CTL, CTL_FAST | (8'd1 << CTL_MASK_ALL));
    tick();                              // masked: timer moves, nothing raised

    // --- random part ---
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      no_idle = (i >= CALM_FIRST) && (i < CALM_LAST);
      random_word();
    end
    no_idle = 1'b0;
    in_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
